>>> hw/rtl/psa_pkg.sv
// psa_pkg: shared types and constants for the port slot allocator.
// Used by psa_cell, port_slot_allocator and psa_checker.
package psa_pkg;

    localparam int SLOT_W = 4;
    localparam int PORT_W = 8;
    localparam int STAT_W = 2;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // scan results handed from cell to cell
    typedef struct packed {
        logic lf_valid;
        logic hint_occ;
        logic port_occ;
    } t_link_flags;

    // occupancy write broadcast to all cells
    typedef struct packed {
        logic en;
        logic val;
    } t_cell_wr;

endpackage

>>> hw/rtl/psa_cell.sv
// psa_cell: one occupancy bit of the slot table plus one stage of the scan chain.
// Depends on psa_pkg.
module psa_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tok,
    input  psa_pkg::t_link_flags  i_link,
    input  logic [IDX_W-1:0]      i_lf_idx,
    input  logic [IDX_W-1:0]      i_hint,
    input  logic [IDX_W-1:0]      i_port_idx,
    input  psa_pkg::t_cell_wr     i_wr,
    input  logic [IDX_W-1:0]      i_wr_idx,
    output logic                  o_tok,
    output psa_pkg::t_link_flags  o_link,
    output logic [IDX_W-1:0]      o_lf_idx
);
    import psa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             r_occ;
    logic             n_occ;
    logic             r_tok;
    t_link_flags      r_link;
    t_link_flags      n_link;
    logic [IDX_W-1:0] r_lf_idx;
    logic [IDX_W-1:0] n_lf_idx;

    always_comb begin
        n_occ = r_occ;
        if (i_wr.en && (i_wr_idx == MY_IDX)) begin
            n_occ = i_wr.val;
        end
    end

    always_comb begin
        n_link   = i_link;
        n_lf_idx = i_lf_idx;
        if (!r_occ && !i_link.lf_valid) begin
            n_link.lf_valid = 1'b1;
            n_lf_idx        = MY_IDX;
        end
        if (i_hint == MY_IDX) begin
            n_link.hint_occ = r_occ;
        end
        if (i_port_idx == MY_IDX) begin
            n_link.port_occ = r_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_tok <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_tok <= i_tok;
        end
    end

    // scan data only moves with the token, then holds for the commit
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_link   <= n_link;
            r_lf_idx <= n_lf_idx;
        end
    end

    assign o_tok    = r_tok;
    assign o_link   = r_link;
    assign o_lf_idx = r_lf_idx;

endmodule

>>> hw/rtl/port_slot_allocator.sv
// port_slot_allocator: top level, grants the hint slot if free, else the lowest free slot.
// A command scans the slot table by passing a token down the chain of NUM_SLOTS cells
// and commits when the token leaves the last cell. One item in flight: the next input
// is accepted only once the result is committed and the block is back in idle.
// Reset (i_rst_n low, synchronous) frees every slot, zeroes the hint, drops tvalid.
// Depends on psa_pkg and psa_cell.
module port_slot_allocator #(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [0] command, [8:1] port_number, [15:9] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] status, [5:2] slot, [7:6] zero
);
    import psa_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [PORT_W:0]  NUM_EXT  = (PORT_W + 1)'(NUM_SLOTS);

    t_state              r_state;
    t_state              n_state;
    logic                r_cmd;
    logic [PORT_W-1:0]   r_port;
    logic [IDX_W-1:0]    r_hint;
    logic [IDX_W-1:0]    n_hint;
    logic                r_start;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                s_accept;
    logic                commit_fire;
    logic [STAT_W-1:0]   c_status;
    logic [SLOT_W-1:0]   c_slot;
    t_cell_wr            c_wr;
    logic [IDX_W-1:0]    c_wr_idx;
    logic [IDX_W-1:0]    given;
    logic [IDX_W-1:0]    port_idx;
    logic                alloc_busy;
    logic                port_range;
    logic                rel_ok;

    logic                tok     [NUM_SLOTS+1];
    t_link_flags         link    [NUM_SLOTS+1];
    logic [IDX_W-1:0]    lf_idx  [NUM_SLOTS+1];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign port_idx      = r_port[IDX_W-1:0];

    assign tok[0]    = r_start;
    assign link[0]   = '0;
    assign lf_idx[0] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        psa_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (tok[g]),
            .i_link     (link[g]),
            .i_lf_idx   (lf_idx[g]),
            .i_hint     (r_hint),
            .i_port_idx (port_idx),
            .i_wr       (c_wr),
            .i_wr_idx   (c_wr_idx),
            .o_tok      (tok[g+1]),
            .o_link     (link[g+1]),
            .o_lf_idx   (lf_idx[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok[NUM_SLOTS]) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        commit_fire = (r_state == ST_COMMIT) && (!r_out_valid || m_axis_tready);
        alloc_busy  = link[NUM_SLOTS].hint_occ && !link[NUM_SLOTS].lf_valid;
        given       = (link[NUM_SLOTS].hint_occ && link[NUM_SLOTS].lf_valid) ?
                      lf_idx[NUM_SLOTS] : r_hint;
        port_range  = ({1'b0, r_port} >= NUM_EXT);
        rel_ok      = !port_range && link[NUM_SLOTS].port_occ;
        n_hint      = r_hint;
        c_wr        = '0;
        c_wr_idx    = port_idx;
        if (r_cmd == CMD_ALLOC) begin
            c_slot   = SLOT_W'(given);
            c_status = alloc_busy ? STAT_BUSY : STAT_OK;
            c_wr_idx = given;
            c_wr.val = 1'b1;
            c_wr.en  = commit_fire && !alloc_busy;
            if (commit_fire) begin
                n_hint = (given == LAST_IDX) ? '0 : given + 1'b1;
            end
        end else begin
            c_slot   = r_port[SLOT_W-1:0];
            c_status = port_range ? STAT_RANGE : (rel_ok ? STAT_OK : STAT_BUSY);
            c_wr.val = 1'b0;
            c_wr.en  = commit_fire && rel_ok;
            if (commit_fire && rel_ok && (port_idx < r_hint)) begin
                n_hint = port_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hint      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
            r_start <= s_accept;
            if (commit_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd  <= s_axis_tdata[0];
            r_port <= s_axis_tdata[PORT_W:1];
        end
        if (commit_fire) begin
            r_out_status <= c_status;
            r_out_slot   <= c_slot;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_slot, r_out_status};

endmodule

>>> hw/rtl/psa_checker.sv
// psa_checker: port-level assertions for port_slot_allocator, bound to the top.
// Depends on psa_pkg.
module psa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    import psa_pkg::*;

    // one transaction in flight: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous item in flight");

    // a new result appears only as the block goes back to idle
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result issued while block still busy");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == STAT_OK || m_axis_tdata[1:0] == STAT_RANGE
                           || m_axis_tdata[1:0] == STAT_BUSY))
        else $error("illegal status code");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind port_slot_allocator psa_checker u_psa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/port_slot_allocator_tb.sv
// port_slot_allocator_tb: self-checking bench for the port slot allocator.
// Directed table then biased random allocate/release traffic, checked against a
// local occupancy/hint tracker. Depends on psa_pkg and port_slot_allocator.
module port_slot_allocator_tb;
    import psa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS      = 16;
    localparam int RANDOM_ITEMS   = 925;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = NUM_SLOTS + 8;

    typedef struct packed {
        logic [STAT_W-1:0] stat;
        logic [SLOT_W-1:0] slot;
    } t_grant;

    typedef struct packed {
        logic              cmd;
        logic [PORT_W-1:0] port;
        logic              typed;
        logic [STAT_W-1:0] stat;
        logic [SLOT_W-1:0] slot;
    } t_vector;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [0] command, [8:1] port_number, [15:9] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [1:0] status, [5:2] slot, [7:6] zero

    bit     slot_taken [NUM_SLOTS];
    int     hint;
    t_grant pending_grants [$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;
    bit     sender_pause = 1'b1;

    port_slot_allocator #(.NUM_SLOTS(NUM_SLOTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Tracks the slot table and returns the grant a command should produce.
    function automatic t_grant grant_for(input logic cmd, input logic [PORT_W-1:0] port);
        t_grant g;
        int     given;
        if (cmd == CMD_ALLOC) begin
            if (hint >= NUM_SLOTS) hint = 0;
            if (slot_taken[hint]) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!slot_taken[i]) begin
                        hint = i;
                        break;
                    end
                end
            end
            given = hint;
            hint = (hint + 1 >= NUM_SLOTS) ? 0 : hint + 1;
            g.slot = given[SLOT_W-1:0];
            if (slot_taken[given]) begin
                g.stat = STAT_BUSY;
            end else begin
                slot_taken[given] = 1'b1;
                g.stat = STAT_OK;
            end
        end else begin
            g.slot = port[SLOT_W-1:0];
            if (port >= NUM_SLOTS) begin
                g.stat = STAT_RANGE;
            end else if (!slot_taken[port]) begin
                g.stat = STAT_BUSY;
            end else begin
                slot_taken[port] = 1'b0;
                if (int'(port) < hint) hint = int'(port);
                g.stat = STAT_OK;
            end
        end
        return g;
    endfunction

    task automatic send_command(input logic cmd, input logic [PORT_W-1:0] port,
                                input logic typed, input t_grant typed_grant);
        t_grant g;
        while (sender_pause && !calm && $urandom_range(0, 99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, port, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        g = grant_for(cmd, port);
        pending_grants.push_back(typed ? typed_grant : g);
    endtask

    task automatic wait_for_grants();
        s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && (calm || $urandom_range(0, 99) >= 35);
    end

    always @(posedge i_clk) begin : result_check
        t_grant want;
        t_grant got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.stat = m_axis_tdata[1:0];
            got.slot = m_axis_tdata[5:2];
            if (pending_grants.size() == 0) begin
                $error("unexpected result transaction: status=%0d slot=%0d",
                       got.stat, got.slot);
                errors++;
            end else begin
                want = pending_grants.pop_front();
                if (got.stat !== want.stat) begin
                    $error("status: expected %0d, actual %0d", want.stat, got.stat);
                    errors++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, got.slot);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_vector           rows [16];
        t_grant            tg;
        int                alloc_pct;
        int                busy_list [$];
        logic              cmd;
        logic [PORT_W-1:0] port;

        for (int i = 0; i < NUM_SLOTS; i++) slot_taken[i] = 1'b0;
        hint = 0;

        rows = '{
            '{CMD_ALLOC,   8'd0,   1'b1, STAT_OK,    4'd0},
            '{CMD_ALLOC,   8'd255, 1'b1, STAT_OK,    4'd1},
            '{CMD_RELEASE, 8'd255, 1'b1, STAT_RANGE, 4'd15},
            '{CMD_RELEASE, 8'd16,  1'b1, STAT_RANGE, 4'd0},
            '{CMD_RELEASE, 8'd128, 1'b1, STAT_RANGE, 4'd0},
            '{CMD_RELEASE, 8'd15,  1'b1, STAT_BUSY,  4'd15},
            '{CMD_RELEASE, 8'd2,   1'b1, STAT_BUSY,  4'd2},
            '{CMD_RELEASE, 8'd0,   1'b1, STAT_OK,    4'd0},
            '{CMD_RELEASE, 8'd0,   1'b1, STAT_BUSY,  4'd0},
            '{CMD_ALLOC,   8'd0,   1'b0, STAT_OK,    4'd0},
            '{CMD_ALLOC,   8'd0,   1'b0, STAT_OK,    4'd0},
            '{CMD_RELEASE, 8'd1,   1'b0, STAT_OK,    4'd0},
            '{CMD_ALLOC,   8'hAA,  1'b0, STAT_OK,    4'd0},
            '{CMD_RELEASE, 8'h55,  1'b1, STAT_RANGE, 4'd5},
            '{CMD_ALLOC,   8'd0,   1'b0, STAT_OK,    4'd0},
            '{CMD_RELEASE, 8'd15,  1'b1, STAT_BUSY,  4'd15}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            tg.stat = rows[i].stat;
            tg.slot = rows[i].slot;
            send_command(rows[i].cmd, rows[i].port, rows[i].typed, tg);
        end
        wait_for_grants();

        // phases alternate fill-heavy, drain-heavy and balanced traffic
        alloc_pct = 85;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 400 && n < 600);
            if (n % 60 == 0) begin
                case ((n / 60) % 3)
                    0: begin
                        alloc_pct = 85;
                    end
                    1: begin
                        alloc_pct = 20;
                    end
                    default: begin
                        alloc_pct = 50;
                    end
                endcase
            end
            if (n % 300 == 150) wait_for_grants();

            cmd  = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_RELEASE;
            port = PORT_W'($urandom_range(0, 255));
            if (cmd == CMD_RELEASE && $urandom_range(0, 99) < 75) begin
                busy_list.delete();
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (slot_taken[i]) busy_list.push_back(i);
                if (busy_list.size() != 0 && $urandom_range(0, 99) < 75)
                    port = PORT_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
                else
                    port = PORT_W'($urandom_range(0, NUM_SLOTS - 1));
            end
            tg = '0;
            send_command(cmd, port, 1'b0, tg);
        end
        calm = 1'b0;

        wait_for_grants();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/psa_pkg.sv
hw/rtl/psa_cell.sv
hw/rtl/port_slot_allocator.sv
hw/rtl/psa_checker.sv
tb/sv/port_slot_allocator_tb.sv
